### rtl/core/lkg_pkg.sv
`timescale 1ns / 1ps

package lkg_pkg;

    // Input transaction: one IMU sample
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } in_item_t;

    // Result transaction: force estimate
    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               saturated;
    } out_item_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_BODY_MASS   = 3'd0;
    localparam logic [2:0] CFG_SHANK_LEN   = 3'd1;
    localparam logic [2:0] CFG_THIGH_LEN   = 3'd2;
    localparam logic [2:0] CFG_SHANK_FRAC  = 3'd3;
    localparam logic [2:0] CFG_THIGH_FRAC  = 3'd4;
    localparam logic [2:0] CFG_PERIOD      = 3'd5;
    localparam logic [2:0] CFG_RATE        = 3'd6;

    // Shared multiplier geometry
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 64;

    localparam int TRIG_W  = 18;  // sin/cos in Q2.14 with headroom
    localparam int LEN_W   = 19;  // segment vectors, 1/65536 m

    // Arithmetic constants
    localparam int PHASE_SCALE  = 83443;
    localparam int DIV25_RECIP  = 21474837;  // ceil(2^29 / 25)
    localparam int DIV25_SHIFT  = 29;
    localparam int DIV25_BIAS   = 12;
    localparam int GRAVITY_Q16  = 642908;
    localparam int FRAC_SHANK   = 3736;
    localparam int FRAC_THIGH   = 9280;
    localparam int FRAC_HIP     = 19753;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int CORDIC_STEPS = 16;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_WB,
        ST_TRIG,
        ST_COMMIT,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        WB_NONE,
        WB_PH_ROLL,
        WB_PH_YAW,
        WB_DIVPREP,
        WB_LS0,
        WB_LS2,
        WB_LT0,
        WB_LT2,
        WB_LSC0,
        WB_LSC2,
        WB_LTC0,
        WB_LTC2,
        WB_VI,
        WB_VS,
        WB_VK,
        WB_WT,
        WB_VT,
        WB_VH,
        WB_AS,
        WB_AT,
        WB_AH,
        WB_MS,
        WB_MT,
        WB_MH,
        WB_FORCE
    } wb_code_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clr;
        logic sub;
    } mac_ctrl_t;

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh000000007FFFFFFF;
        lo = 64'shFFFFFFFF80000000;
        if (v > hi) begin
            return {1'b1, 32'h7FFFFFFF};
        end else if (v < lo) begin
            return {1'b1, 32'h80000000};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

### rtl/core/lkg_mac.sv
`timescale 1ns / 1ps

module lkg_mac (
    input  logic                                   aclk,
    input  lkg_pkg::mac_ctrl_t                     ctrl,
    input  logic signed [lkg_pkg::MUL_A_W-1:0]     mul_a,
    input  logic signed [lkg_pkg::MUL_B_W-1:0]     mul_b,
    output logic signed [lkg_pkg::ACC_W-1:0]       acc
);

    logic signed [lkg_pkg::PROD_W-1:0] prod_reg;
    logic signed [lkg_pkg::ACC_W-1:0]  acc_reg;
    logic signed [lkg_pkg::ACC_W-1:0]  acc_next;
    logic signed [lkg_pkg::ACC_W-1:0]  prod_ext;

    always_comb begin
        prod_ext = lkg_pkg::ACC_W'(prod_reg);
        acc_next = (ctrl.clr ? '0 : acc_reg) + (ctrl.sub ? -prod_ext : prod_ext);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/core/lkg_cordic.sv
`timescale 1ns / 1ps

module lkg_cordic #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [31:0]                          phase,
    output logic                                 done,
    output logic signed [lkg_pkg::TRIG_W-1:0]    sin_q,
    output logic signed [lkg_pkg::TRIG_W-1:0]    cos_q
);

    localparam int SH = 32 - TRIG_TABLE_BITS;
    localparam logic [31:0] HALF_STEP = 32'(1) << (SH - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [3:0]         cnt_reg;
    logic               neg_reg;
    logic signed [32:0] x_reg;
    logic signed [32:0] y_reg;
    logic signed [33:0] z_reg;

    logic [31:0]        ph_round;
    logic [31:0]        ph_q;
    logic [31:0]        ph_half;
    logic [31:0]        ph_fold;
    logic signed [32:0] x_sh;
    logic signed [32:0] y_sh;
    logic signed [32:0] x_rnd;
    logic signed [32:0] y_rnd;

    always_comb begin
        // Quantize to the table grid, then fold the left half plane
        ph_round = phase + HALF_STEP;
        ph_q     = {ph_round[31:SH], SH'(0)};
        ph_half  = ph_q + 32'h40000000;
        ph_fold  = ph_half[31] ? (ph_q ^ 32'h80000000) : ph_q;
        x_sh     = x_reg >>> cnt_reg;
        y_sh     = y_reg >>> cnt_reg;
        x_rnd    = (x_reg + 33'sd32768) >>> 16;
        y_rnd    = (y_reg + 33'sd32768) >>> 16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == 4'(lkg_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= ph_half[31];
            x_reg   <= 33'(lkg_pkg::CORDIC_GAIN);
            y_reg   <= '0;
            z_reg   <= 34'($signed(ph_fold));
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - 34'(lkg_pkg::ATAN_TURNS[cnt_reg]);
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + 34'(lkg_pkg::ATAN_TURNS[cnt_reg]);
            end
        end
    end

    assign done  = done_reg;
    assign sin_q = neg_reg ? -lkg_pkg::TRIG_W'(y_rnd) : lkg_pkg::TRIG_W'(y_rnd);
    assign cos_q = neg_reg ? -lkg_pkg::TRIG_W'(x_rnd) : lkg_pkg::TRIG_W'(x_rnd);

endmodule

### rtl/core/leg_kinematics_grf_estimator_core.sv
`timescale 1ns / 1ps
// Ground reaction force estimator for one leg, fed one IMU sample per transaction.
// Input channel s_valid/s_ready/s_data carries acceleration, angular rate and
// roll/pitch/yaw; result channel m_valid/m_ready/m_data carries the force
// vector in 1/16 N plus a flag that is set when any value clipped.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes one register
// per cycle; write it only while no sample is in flight.
// One sample is processed at a time: 57 products pass one after another
// through the shared 34x26 multiplier (a multiply step and an accumulate
// step each, plus a write-back step where a value is stored), and
// sin(roll) and cos(yaw) each take a 16-step pass through the iterative
// CORDIC unit.
// The result sits in an output register; the core accepts the next sample
// while it waits. If the receiver stalls, the next result is held inside the
// core until the output register frees, and no new sample is taken meanwhile.
// Reset (aresetn low, synchronous) restores the register defaults and clears
// the velocity, acceleration and angle history.
module leg_kinematics_grf_estimator_core #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lkg_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lkg_pkg::out_item_t  m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_wdata
);

    localparam int AW = lkg_pkg::MUL_A_W;
    localparam int BW = lkg_pkg::MUL_B_W;
    localparam int TW = lkg_pkg::TRIG_W;
    localparam int LW = lkg_pkg::LEN_W;
    localparam logic [5:0] LAST_OP = 6'd56;

    // Configuration registers
    logic [15:0] body_mass_reg;
    logic [7:0]  shank_len_reg;
    logic [7:0]  thigh_len_reg;
    logic [15:0] shank_frac_reg;
    logic [15:0] thigh_frac_reg;
    logic [23:0] period_reg;
    logic [15:0] rate_reg;

    // Sample history
    logic signed [15:0] pacc_reg [3];
    logic signed [31:0] iv_reg   [3];
    logic signed [31:0] pvs_reg  [3];
    logic signed [31:0] pvt_reg  [3];
    logic signed [31:0] pvh_reg  [3];
    logic signed [15:0] pang_reg [3];

    // Working values for the current sample
    logic signed [15:0] a_reg    [3];
    logic signed [15:0] w_reg    [3];
    logic signed [15:0] ang_reg  [3];
    logic signed [TW-1:0] sr_reg;
    logic signed [TW-1:0] cy_reg;
    logic [22:0]        tmag_reg;
    logic               tneg_reg;
    logic signed [LW-1:0] ls_reg  [3];
    logic signed [LW-1:0] lt_reg  [3];
    logic signed [LW-1:0] lsc_reg [3];
    logic signed [LW-1:0] ltc_reg [3];
    logic signed [31:0] vs_reg   [3];
    logic signed [31:0] vk_reg   [3];
    logic signed [31:0] wt_reg   [3];
    logic signed [31:0] vt_reg   [3];
    logic signed [31:0] vh_reg   [3];
    logic signed [32:0] as_reg   [3];
    logic signed [32:0] at_reg   [3];
    logic signed [32:0] ah_reg   [3];
    logic [23:0]        ms_reg;
    logic [23:0]        mt_reg;
    logic [23:0]        mh_reg;
    logic signed [31:0] f_reg    [3];
    logic               sat_reg;

    lkg_pkg::state_t    state_reg;
    lkg_pkg::state_t    state_next;
    logic [5:0]         op_reg;

    logic               m_valid_reg;
    lkg_pkg::out_item_t m_data_reg;

    // Micro-op decode
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic                 op_clr;
    logic                 op_sub;
    lkg_pkg::wb_code_t    op_wb;
    logic [1:0]           op_ax;

    lkg_pkg::mac_ctrl_t   mac_ctrl;
    logic signed [lkg_pkg::ACC_W-1:0] acc;

    logic                 cordic_start;
    logic                 cordic_done;
    logic signed [TW-1:0] cordic_sin;
    logic signed [TW-1:0] cordic_cos;

    logic                 accept;
    logic                 op_adv;
    logic                 wb_en;
    logic                 commit;
    logic                 out_load;
    logic                 op_has_wb;
    logic                 op_is_ph;

    // Write-back arithmetic
    logic signed [63:0]   wb_base;
    logic signed [63:0]   wb_add;
    logic signed [63:0]   clip_in;
    logic [32:0]          clip_res;
    logic signed [31:0]   clip_val;
    logic                 clip_hit;
    logic signed [63:0]   acc_abs;
    logic [18:0]          div_q;
    logic signed [32:0]   grav;

    lkg_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .acc   (acc)
    );

    lkg_cordic #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .phase   (acc[31:0]),
        .done    (cordic_done),
        .sin_q   (cordic_sin),
        .cos_q   (cordic_cos)
    );

    // Micro-program: operands, accumulate mode and write-back for each step
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        op_clr = 1'b1;
        op_sub = 1'b0;
        op_wb  = lkg_pkg::WB_NONE;
        op_ax  = 2'd0;
        unique case (op_reg)
            // trig phases for roll and yaw
            6'd0: begin
                mul_a = AW'(ang_reg[0]); mul_b = BW'(lkg_pkg::PHASE_SCALE);
                op_wb = lkg_pkg::WB_PH_ROLL;
            end
            6'd1: begin
                mul_a = AW'(ang_reg[2]); mul_b = BW'(lkg_pkg::PHASE_SCALE);
                op_wb = lkg_pkg::WB_PH_YAW;
            end
            // segment vectors: len*trig, then rounded divide by 25
            6'd2: begin
                mul_a = AW'(shank_len_reg); mul_b = BW'(sr_reg); op_wb = lkg_pkg::WB_DIVPREP;
            end
            6'd3: begin
                mul_a = AW'(tmag_reg); mul_b = BW'(lkg_pkg::DIV25_RECIP);
                op_wb = lkg_pkg::WB_LS0;
            end
            6'd4: begin
                mul_a = AW'(shank_len_reg); mul_b = BW'(cy_reg); op_wb = lkg_pkg::WB_DIVPREP;
            end
            6'd5: begin
                mul_a = AW'(tmag_reg); mul_b = BW'(lkg_pkg::DIV25_RECIP);
                op_wb = lkg_pkg::WB_LS2;
            end
            6'd6: begin
                mul_a = AW'(thigh_len_reg); mul_b = BW'(sr_reg); op_wb = lkg_pkg::WB_DIVPREP;
            end
            6'd7: begin
                mul_a = AW'(tmag_reg); mul_b = BW'(lkg_pkg::DIV25_RECIP);
                op_wb = lkg_pkg::WB_LT0;
            end
            6'd8: begin
                mul_a = AW'(thigh_len_reg); mul_b = BW'(cy_reg); op_wb = lkg_pkg::WB_DIVPREP;
            end
            6'd9: begin
                mul_a = AW'(tmag_reg); mul_b = BW'(lkg_pkg::DIV25_RECIP);
                op_wb = lkg_pkg::WB_LT2;
            end
            // centre-of-mass vectors
            6'd10: begin
                mul_a = AW'(shank_frac_reg); mul_b = BW'(ls_reg[0]); op_wb = lkg_pkg::WB_LSC0;
            end
            6'd11: begin
                mul_a = AW'(shank_frac_reg); mul_b = BW'(ls_reg[2]); op_wb = lkg_pkg::WB_LSC2;
            end
            6'd12: begin
                mul_a = AW'(17'h10000 - 17'(thigh_frac_reg)); mul_b = BW'(lt_reg[0]);
                op_wb = lkg_pkg::WB_LTC0;
            end
            6'd13: begin
                mul_a = AW'(17'h10000 - 17'(thigh_frac_reg)); mul_b = BW'(lt_reg[2]);
                op_wb = lkg_pkg::WB_LTC2;
            end
            // IMU velocity, trapezoid rule
            6'd14, 6'd15, 6'd16: begin
                op_ax = 2'(op_reg - 6'd14);
                mul_a = AW'(period_reg);
                mul_b = BW'(17'(a_reg[op_ax]) + 17'(pacc_reg[op_ax]));
                op_wb = lkg_pkg::WB_VI;
            end
            // shank velocity: w x lsc (l[1] is zero)
            6'd17: begin
                mul_a = AW'(w_reg[1]); mul_b = BW'(lsc_reg[2]);
                op_wb = lkg_pkg::WB_VS; op_ax = 2'd0;
            end
            6'd18: begin
                mul_a = AW'(w_reg[2]); mul_b = BW'(lsc_reg[0]);
            end
            6'd19: begin
                mul_a = AW'(w_reg[0]); mul_b = BW'(lsc_reg[2]);
                op_clr = 1'b0; op_sub = 1'b1; op_wb = lkg_pkg::WB_VS; op_ax = 2'd1;
            end
            6'd20: begin
                mul_a = AW'(w_reg[1]); mul_b = BW'(lsc_reg[0]);
                op_sub = 1'b1; op_wb = lkg_pkg::WB_VS; op_ax = 2'd2;
            end
            // knee velocity: w x ls
            6'd21: begin
                mul_a = AW'(w_reg[1]); mul_b = BW'(ls_reg[2]);
                op_wb = lkg_pkg::WB_VK; op_ax = 2'd0;
            end
            6'd22: begin
                mul_a = AW'(w_reg[2]); mul_b = BW'(ls_reg[0]);
            end
            6'd23: begin
                mul_a = AW'(w_reg[0]); mul_b = BW'(ls_reg[2]);
                op_clr = 1'b0; op_sub = 1'b1; op_wb = lkg_pkg::WB_VK; op_ax = 2'd1;
            end
            6'd24: begin
                mul_a = AW'(w_reg[1]); mul_b = BW'(ls_reg[0]);
                op_sub = 1'b1; op_wb = lkg_pkg::WB_VK; op_ax = 2'd2;
            end
            // thigh rate from angle differences
            6'd25, 6'd26, 6'd27: begin
                op_ax = 2'(op_reg - 6'd25);
                mul_a = AW'(17'(ang_reg[op_ax]) - 17'(pang_reg[op_ax]));
                mul_b = BW'(rate_reg);
                op_wb = lkg_pkg::WB_WT;
            end
            // thigh velocity: wt x ltc
            6'd28: begin
                mul_a = AW'(wt_reg[1]); mul_b = BW'(ltc_reg[2]);
                op_wb = lkg_pkg::WB_VT; op_ax = 2'd0;
            end
            6'd29: begin
                mul_a = AW'(wt_reg[2]); mul_b = BW'(ltc_reg[0]);
            end
            6'd30: begin
                mul_a = AW'(wt_reg[0]); mul_b = BW'(ltc_reg[2]);
                op_clr = 1'b0; op_sub = 1'b1; op_wb = lkg_pkg::WB_VT; op_ax = 2'd1;
            end
            6'd31: begin
                mul_a = AW'(wt_reg[1]); mul_b = BW'(ltc_reg[0]);
                op_sub = 1'b1; op_wb = lkg_pkg::WB_VT; op_ax = 2'd2;
            end
            // hip velocity: wt x lt
            6'd32: begin
                mul_a = AW'(wt_reg[1]); mul_b = BW'(lt_reg[2]);
                op_wb = lkg_pkg::WB_VH; op_ax = 2'd0;
            end
            6'd33: begin
                mul_a = AW'(wt_reg[2]); mul_b = BW'(lt_reg[0]);
            end
            6'd34: begin
                mul_a = AW'(wt_reg[0]); mul_b = BW'(lt_reg[2]);
                op_clr = 1'b0; op_sub = 1'b1; op_wb = lkg_pkg::WB_VH; op_ax = 2'd1;
            end
            6'd35: begin
                mul_a = AW'(wt_reg[1]); mul_b = BW'(lt_reg[0]);
                op_sub = 1'b1; op_wb = lkg_pkg::WB_VH; op_ax = 2'd2;
            end
            // segment accelerations
            6'd36, 6'd37, 6'd38: begin
                op_ax = 2'(op_reg - 6'd36);
                mul_a = AW'(33'(vs_reg[op_ax]) - 33'(pvs_reg[op_ax]));
                mul_b = BW'(rate_reg);
                op_wb = lkg_pkg::WB_AS;
            end
            6'd39, 6'd40, 6'd41: begin
                op_ax = 2'(op_reg - 6'd39);
                mul_a = AW'(33'(vt_reg[op_ax]) - 33'(pvt_reg[op_ax]));
                mul_b = BW'(rate_reg);
                op_wb = lkg_pkg::WB_AT;
            end
            6'd42, 6'd43, 6'd44: begin
                op_ax = 2'(op_reg - 6'd42);
                mul_a = AW'(33'(vh_reg[op_ax]) - 33'(pvh_reg[op_ax]));
                mul_b = BW'(rate_reg);
                op_wb = lkg_pkg::WB_AH;
            end
            // segment masses
            6'd45: begin
                mul_a = AW'(body_mass_reg); mul_b = BW'(lkg_pkg::FRAC_SHANK);
                op_wb = lkg_pkg::WB_MS;
            end
            6'd46: begin
                mul_a = AW'(body_mass_reg); mul_b = BW'(lkg_pkg::FRAC_THIGH);
                op_wb = lkg_pkg::WB_MT;
            end
            6'd47: begin
                mul_a = AW'(body_mass_reg); mul_b = BW'(lkg_pkg::FRAC_HIP);
                op_wb = lkg_pkg::WB_MH;
            end
            // force: mass-weighted sum per axis
            6'd48, 6'd51, 6'd54: begin
                op_ax = (op_reg == 6'd48) ? 2'd0 : ((op_reg == 6'd51) ? 2'd1 : 2'd2);
                mul_a = AW'(as_reg[op_ax]); mul_b = BW'(ms_reg);
            end
            6'd49, 6'd52, 6'd55: begin
                op_ax = (op_reg == 6'd49) ? 2'd0 : ((op_reg == 6'd52) ? 2'd1 : 2'd2);
                mul_a = AW'(at_reg[op_ax]); mul_b = BW'(mt_reg);
                op_clr = 1'b0;
            end
            6'd50, 6'd53, 6'd56: begin
                op_ax = (op_reg == 6'd50) ? 2'd0 : ((op_reg == 6'd53) ? 2'd1 : 2'd2);
                mul_a = AW'(ah_reg[op_ax]); mul_b = BW'(mh_reg);
                op_clr = 1'b0; op_wb = lkg_pkg::WB_FORCE;
            end
            default: begin
                op_wb = lkg_pkg::WB_NONE;
            end
        endcase
    end

    assign op_has_wb = (op_wb != lkg_pkg::WB_NONE);
    assign op_is_ph  = (op_wb == lkg_pkg::WB_PH_ROLL) || (op_wb == lkg_pkg::WB_PH_YAW);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lkg_pkg::ST_IDLE: begin
                if (s_valid) state_next = lkg_pkg::ST_MUL;
            end
            lkg_pkg::ST_MUL: begin
                state_next = lkg_pkg::ST_ACC;
            end
            lkg_pkg::ST_ACC: begin
                state_next = op_has_wb ? lkg_pkg::ST_WB : lkg_pkg::ST_MUL;
            end
            lkg_pkg::ST_WB: begin
                priority if (op_is_ph) begin
                    state_next = lkg_pkg::ST_TRIG;
                end else if (op_reg == LAST_OP) begin
                    state_next = lkg_pkg::ST_COMMIT;
                end else begin
                    state_next = lkg_pkg::ST_MUL;
                end
            end
            lkg_pkg::ST_TRIG: begin
                if (cordic_done) state_next = lkg_pkg::ST_MUL;
            end
            lkg_pkg::ST_COMMIT: begin
                state_next = lkg_pkg::ST_OUT;
            end
            lkg_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = lkg_pkg::ST_IDLE;
            end
            default: begin
                state_next = lkg_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready      = 1'b0;
        mac_ctrl     = '0;
        cordic_start = 1'b0;
        op_adv       = 1'b0;
        wb_en        = 1'b0;
        commit       = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            lkg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            lkg_pkg::ST_MUL: begin
                mac_ctrl.mul_en = 1'b1;
            end
            lkg_pkg::ST_ACC: begin
                mac_ctrl.acc_en = 1'b1;
                mac_ctrl.clr    = op_clr;
                mac_ctrl.sub    = op_sub;
                op_adv          = !op_has_wb;
            end
            lkg_pkg::ST_WB: begin
                wb_en        = 1'b1;
                cordic_start = op_is_ph;
                op_adv       = !op_is_ph && (op_reg != LAST_OP);
            end
            lkg_pkg::ST_TRIG: begin
                op_adv = cordic_done;
            end
            lkg_pkg::ST_COMMIT: begin
                commit = 1'b1;
            end
            lkg_pkg::ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // Write-back datapath: shift the accumulator, add the base, clip to 32 bits
    always_comb begin
        wb_base = '0;
        wb_add  = acc;
        unique case (op_wb)
            lkg_pkg::WB_VI: begin
                wb_base = 64'(iv_reg[op_ax]);
                wb_add  = acc >>> 17;
            end
            lkg_pkg::WB_VS, lkg_pkg::WB_VK: begin
                wb_base = 64'(iv_reg[op_ax]);
                wb_add  = acc >>> 10;
            end
            lkg_pkg::WB_WT: begin
                wb_add = acc >>> 3;
            end
            lkg_pkg::WB_VT, lkg_pkg::WB_VH: begin
                wb_base = 64'(vk_reg[op_ax]);
                wb_add  = acc >>> 10;
            end
            lkg_pkg::WB_FORCE: begin
                wb_base = 64'sd134217728;
            end
            default: begin
                wb_base = '0;
            end
        endcase
        clip_in = wb_base + wb_add;
        if (op_wb == lkg_pkg::WB_FORCE) begin
            clip_in = clip_in >>> 28;
        end
        clip_res = lkg_pkg::sat32(clip_in);
        clip_val = $signed(clip_res[31:0]);
        clip_hit = clip_res[32]
                && (op_wb == lkg_pkg::WB_VI || op_wb == lkg_pkg::WB_VS
                 || op_wb == lkg_pkg::WB_VK || op_wb == lkg_pkg::WB_WT
                 || op_wb == lkg_pkg::WB_VT || op_wb == lkg_pkg::WB_VH
                 || op_wb == lkg_pkg::WB_AS || op_wb == lkg_pkg::WB_AT
                 || op_wb == lkg_pkg::WB_AH || op_wb == lkg_pkg::WB_FORCE);
        acc_abs = acc[63] ? -acc : acc;
        div_q   = acc[lkg_pkg::DIV25_SHIFT +: 19];
        grav    = (op_ax == 2'd2) ? 33'(lkg_pkg::GRAVITY_Q16) : '0;
    end

    // Control state, configuration and history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lkg_pkg::ST_IDLE;
            op_reg         <= '0;
            m_valid_reg    <= 1'b0;
            body_mass_reg  <= 16'd19200;
            shank_len_reg  <= 8'd40;
            thigh_len_reg  <= 8'd50;
            shank_frac_reg <= 16'd37526;
            thigh_frac_reg <= 16'd26837;
            period_reg     <= 24'd83886;
            rate_reg       <= 16'd200;
            for (int i = 0; i < 3; i++) begin
                pacc_reg[i] <= '0;
                iv_reg[i]   <= '0;
                pvs_reg[i]  <= '0;
                pvt_reg[i]  <= '0;
                pvh_reg[i]  <= '0;
                pang_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                op_reg <= '0;
            end else if (op_adv) begin
                op_reg <= op_reg + 6'd1;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                unique case (cfg_index)
                    lkg_pkg::CFG_BODY_MASS:  body_mass_reg  <= cfg_wdata[15:0];
                    lkg_pkg::CFG_SHANK_LEN:  shank_len_reg  <= cfg_wdata[7:0];
                    lkg_pkg::CFG_THIGH_LEN:  thigh_len_reg  <= cfg_wdata[7:0];
                    lkg_pkg::CFG_SHANK_FRAC: shank_frac_reg <= cfg_wdata[15:0];
                    lkg_pkg::CFG_THIGH_FRAC: thigh_frac_reg <= cfg_wdata[15:0];
                    lkg_pkg::CFG_PERIOD:     period_reg     <= cfg_wdata;
                    lkg_pkg::CFG_RATE:       rate_reg       <= cfg_wdata[15:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end

            // IMU velocity is only read as its new value after this point
            if (wb_en && op_wb == lkg_pkg::WB_VI) begin
                iv_reg[op_ax] <= clip_val;
            end

            if (commit) begin
                for (int i = 0; i < 3; i++) begin
                    pacc_reg[i] <= a_reg[i];
                    pvs_reg[i]  <= vs_reg[i];
                    pvt_reg[i]  <= vt_reg[i];
                    pvh_reg[i]  <= vh_reg[i];
                    pang_reg[i] <= ang_reg[i];
                end
            end
        end
    end

    // Per-sample working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg[0]   <= s_data.accel_x;
            a_reg[1]   <= s_data.accel_y;
            a_reg[2]   <= s_data.accel_z;
            w_reg[0]   <= s_data.gyro_x;
            w_reg[1]   <= s_data.gyro_y;
            w_reg[2]   <= s_data.gyro_z;
            ang_reg[0] <= s_data.roll_angle;
            ang_reg[1] <= s_data.pitch_angle;
            ang_reg[2] <= s_data.yaw_angle;
            sat_reg    <= 1'b0;
        end

        if (state_reg == lkg_pkg::ST_TRIG && cordic_done) begin
            if (op_wb == lkg_pkg::WB_PH_ROLL) begin
                sr_reg <= cordic_sin;
            end else begin
                cy_reg <= cordic_cos;
            end
        end

        if (wb_en) begin
            if (clip_hit) begin
                sat_reg <= 1'b1;
            end
            unique case (op_wb)
                lkg_pkg::WB_DIVPREP: begin
                    tmag_reg <= 23'(acc_abs) + 23'(lkg_pkg::DIV25_BIAS);
                    tneg_reg <= acc[63];
                end
                lkg_pkg::WB_LS0: ls_reg[0] <= tneg_reg ? -LW'(div_q) : LW'(div_q);
                lkg_pkg::WB_LS2: ls_reg[2] <= tneg_reg ? -LW'(div_q) : LW'(div_q);
                lkg_pkg::WB_LT0: lt_reg[0] <= tneg_reg ? -LW'(div_q) : LW'(div_q);
                lkg_pkg::WB_LT2: lt_reg[2] <= tneg_reg ? -LW'(div_q) : LW'(div_q);
                lkg_pkg::WB_LSC0: lsc_reg[0] <= LW'(acc >>> 16);
                lkg_pkg::WB_LSC2: lsc_reg[2] <= LW'(acc >>> 16);
                lkg_pkg::WB_LTC0: ltc_reg[0] <= LW'(acc >>> 16);
                lkg_pkg::WB_LTC2: ltc_reg[2] <= LW'(acc >>> 16);
                lkg_pkg::WB_VS: vs_reg[op_ax] <= clip_val;
                lkg_pkg::WB_VK: vk_reg[op_ax] <= clip_val;
                lkg_pkg::WB_WT: wt_reg[op_ax] <= clip_val;
                lkg_pkg::WB_VT: vt_reg[op_ax] <= clip_val;
                lkg_pkg::WB_VH: vh_reg[op_ax] <= clip_val;
                lkg_pkg::WB_AS: as_reg[op_ax] <= 33'(clip_val) - grav;
                lkg_pkg::WB_AT: at_reg[op_ax] <= 33'(clip_val) - grav;
                lkg_pkg::WB_AH: ah_reg[op_ax] <= 33'(clip_val) - grav;
                lkg_pkg::WB_MS: ms_reg <= 24'(acc >>> 8);
                lkg_pkg::WB_MT: mt_reg <= 24'(acc >>> 8);
                lkg_pkg::WB_MH: mh_reg <= 24'(acc >>> 8);
                lkg_pkg::WB_FORCE: f_reg[op_ax] <= clip_val;
                default: begin
                    // phase and IMU velocity are handled elsewhere
                end
            endcase
        end

        if (out_load) begin
            m_data_reg.force_x   <= f_reg[0];
            m_data_reg.force_y   <= f_reg[1];
            m_data_reg.force_z   <= f_reg[2];
            m_data_reg.saturated <= sat_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A sample is only taken from idle and always starts the program
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == lkg_pkg::ST_MUL) && (op_reg == 6'd0))
        else $error("accepted sample did not start the micro-program");

    // CORDIC completes only while the sequencer waits for it
    a_cordic_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == lkg_pkg::ST_TRIG))
        else $error("CORDIC finished outside the trig wait");

    // Step counter never runs past the program
    a_op_range: assert property (@(posedge aclk) disable iff (!aresetn)
        op_reg <= LAST_OP)
        else $error("micro-op index out of range");

    // A finished result reaches the output register
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg && (state_reg == lkg_pkg::ST_IDLE))
        else $error("result not presented after load");

endmodule

### test/grf_checker.sv
`timescale 1ns / 1ps

module grf_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  lkg_pkg::in_item_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  lkg_pkg::out_item_t  m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_wdata,
    output int                  errors,
    output int                  pending
);

    localparam int PHASE_BITS = 10;

    logic [15:0] body_mass;
    logic [7:0]  shank_len, thigh_len;
    logic [15:0] shank_frac, thigh_frac;
    logic [23:0] period;
    logic [15:0] rate_hz;

    longint last_accel[3], vel_imu[3], last_vs[3], last_vt[3], last_vh[3], last_ang[3];

    lkg_pkg::out_item_t force_q[$];

    function automatic longint clip32(longint v, inout bit f);
        if (v > 64'sd2147483647) begin
            f = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            f = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint div25(longint n);
        if (n >= 0) return (n + 12) / 25;
        return -((-n + 12) / 25);
    endfunction

    // sin and cos in Q2.14 of a table-quantized angle
    function automatic void sincos(longint ang, output longint sn, output longint cs);
        logic [31:0] p, idx, ph, t;
        bit neg;
        longint x, y, z, nx;
        p = 32'(ang * lkg_pkg::PHASE_SCALE);
        idx = (p + (32'd1 << (31 - PHASE_BITS))) >> (32 - PHASE_BITS);
        ph = (idx & ((32'd1 << PHASE_BITS) - 1)) << (32 - PHASE_BITS);
        t = ph + 32'h4000_0000;
        neg = 0;
        if (t >= 32'h8000_0000) begin
            ph = ph + 32'h8000_0000;
            neg = 1;
        end
        z = longint'($signed(ph));
        x = lkg_pkg::CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < lkg_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(lkg_pkg::ATAN_TURNS[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(lkg_pkg::ATAN_TURNS[i]);
            end
            x = nx;
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        sn = neg ? -y : y;
        cs = neg ? -x : x;
    endfunction

    function automatic void cross3(longint w[3], longint l[3], output longint o[3]);
        o[0] = (w[1] * l[2] - w[2] * l[1]) >>> 10;
        o[1] = (w[2] * l[0] - w[0] * l[2]) >>> 10;
        o[2] = (w[0] * l[1] - w[1] * l[0]) >>> 10;
    endfunction

    function automatic lkg_pkg::out_item_t estimate_force(lkg_pkg::in_item_t s);
        bit sat;
        longint a[3], w[3], ang[3], ls[3], lsc[3], lt[3], ltc[3];
        longint vi[3], vs[3], vk[3], wt[3], vt[3], vh[3], t1[3], t2[3];
        longint as_[3], at_[3], ah_[3];
        longint sr, cy, dummy, ms, mt, mh, f, rate, fs, ft;
        lkg_pkg::out_item_t r;
        sat = 0;
        rate = rate_hz;
        fs = shank_frac;
        ft = 65536 - longint'(thigh_frac);
        a[0] = s.accel_x; a[1] = s.accel_y; a[2] = s.accel_z;
        w[0] = s.gyro_x; w[1] = s.gyro_y; w[2] = s.gyro_z;
        ang[0] = s.roll_angle; ang[1] = s.pitch_angle; ang[2] = s.yaw_angle;
        sincos(ang[0], sr, dummy);
        sincos(ang[2], dummy, cy);
        ls[0] = div25(longint'(shank_len) * sr);
        ls[1] = 0;
        ls[2] = div25(longint'(shank_len) * cy);
        lt[0] = div25(longint'(thigh_len) * sr);
        lt[1] = 0;
        lt[2] = div25(longint'(thigh_len) * cy);
        for (int i = 0; i < 3; i++) begin
            lsc[i] = (ls[i] * fs) >>> 16;
            ltc[i] = (lt[i] * ft) >>> 16;
            vi[i] = clip32(vel_imu[i] + (((a[i] + last_accel[i]) * longint'(period)) >>> 17),
                           sat);
        end
        cross3(w, lsc, t1);
        cross3(w, ls, t2);
        for (int i = 0; i < 3; i++) begin
            vs[i] = clip32(vi[i] + t1[i], sat);
            vk[i] = clip32(vi[i] + t2[i], sat);
            wt[i] = clip32(((ang[i] - last_ang[i]) * rate) >>> 3, sat);
        end
        cross3(wt, ltc, t1);
        cross3(wt, lt, t2);
        for (int i = 0; i < 3; i++) begin
            vt[i] = clip32(vk[i] + t1[i], sat);
            vh[i] = clip32(vk[i] + t2[i], sat);
            as_[i] = clip32((vs[i] - last_vs[i]) * rate, sat);
            at_[i] = clip32((vt[i] - last_vt[i]) * rate, sat);
            ah_[i] = clip32((vh[i] - last_vh[i]) * rate, sat);
        end
        ms = (longint'(body_mass) * lkg_pkg::FRAC_SHANK) >>> 8;
        mt = (longint'(body_mass) * lkg_pkg::FRAC_THIGH) >>> 8;
        mh = (longint'(body_mass) * lkg_pkg::FRAC_HIP) >>> 8;
        as_[2] -= lkg_pkg::GRAVITY_Q16;
        at_[2] -= lkg_pkg::GRAVITY_Q16;
        ah_[2] -= lkg_pkg::GRAVITY_Q16;
        for (int i = 0; i < 3; i++) begin
            f = ms * as_[i] + mt * at_[i] + mh * ah_[i];
            f = clip32((f + (64'sd1 <<< 27)) >>> 28, sat);
            if (i == 0) r.force_x = 32'(f);
            else if (i == 1) r.force_y = 32'(f);
            else r.force_z = 32'(f);
        end
        for (int i = 0; i < 3; i++) begin
            last_accel[i] = a[i];
            vel_imu[i] = vi[i];
            last_vs[i] = vs[i];
            last_vt[i] = vt[i];
            last_vh[i] = vh[i];
            last_ang[i] = ang[i];
        end
        r.saturated = sat;
        return r;
    endfunction

    task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;
    assign pending = force_q.size();

    always @(posedge aclk) begin
        lkg_pkg::out_item_t want;
        if (!aresetn) begin
            body_mass <= 16'd19200;
            shank_len <= 8'd40;
            thigh_len <= 8'd50;
            shank_frac <= 16'd37526;
            thigh_frac <= 16'd26837;
            period <= 24'd83886;
            rate_hz <= 16'd200;
            for (int i = 0; i < 3; i++) begin
                last_accel[i] = 0; vel_imu[i] = 0; last_vs[i] = 0;
                last_vt[i] = 0; last_vh[i] = 0; last_ang[i] = 0;
            end
            force_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    lkg_pkg::CFG_BODY_MASS:  body_mass <= cfg_wdata[15:0];
                    lkg_pkg::CFG_SHANK_LEN:  shank_len <= cfg_wdata[7:0];
                    lkg_pkg::CFG_THIGH_LEN:  thigh_len <= cfg_wdata[7:0];
                    lkg_pkg::CFG_SHANK_FRAC: shank_frac <= cfg_wdata[15:0];
                    lkg_pkg::CFG_THIGH_FRAC: thigh_frac <= cfg_wdata[15:0];
                    lkg_pkg::CFG_PERIOD:     period <= cfg_wdata;
                    lkg_pkg::CFG_RATE:       rate_hz <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) force_q.push_back(estimate_force(s_data));
            if (m_valid && m_ready) begin
                if (force_q.size() == 0) begin
                    $display("unexpected result transaction at %0t", $realtime);
                    errors++;
                end else begin
                    want = force_q.pop_front();
                    if (m_data.force_x !== want.force_x)
                        report("force_x", m_data.force_x, want.force_x);
                    if (m_data.force_y !== want.force_y)
                        report("force_y", m_data.force_y, want.force_y);
                    if (m_data.force_z !== want.force_z)
                        report("force_z", m_data.force_z, want.force_z);
                    if (m_data.saturated !== want.saturated)
                        report("saturated", m_data.saturated, want.saturated);
                end
            end
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int LATENCY     = 250;
    localparam int HOLD_CYCLES = 3000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    lkg_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 0;
    lkg_pkg::out_item_t m_data;
    logic               cfg_we = 0;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_wdata = '0;
    logic               hold_req = 0;   // ask the receiver for one long hold-off
    int                 errors, pending;
    int                 cycles = 0;

    always #1 aclk = ~aclk;

    leg_kinematics_grf_estimator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    grf_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver: stall on its own pattern; on request, hold off for a long
    // stretch so the core backs up and drops s_ready.
    initial begin
        int mode;
        int span;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req <= 0;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 400);
                repeat (span) begin
                    if (hold_req) break;
                    case (mode)
                        0: m_ready <= 1;
                        1: m_ready <= ($urandom_range(0, 1) == 0);
                        2: m_ready <= ($urandom_range(0, 7) == 0);
                        default: m_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    int burst_left = 0;

    // Offer one sample and hold it until the transaction completes; gaps
    // fall between bursts of random length.
    task automatic send_sample(lkg_pkg::in_item_t item);
        int gap;
        s_valid <= 1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
            if (gap > 0) begin
                s_valid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Wait for every outstanding result, then let the core settle.
    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (pending != 0);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // Write all registers back to back; lower the enable afterward.
    task automatic load_settings(logic [15:0] mass, logic [7:0] sl, logic [7:0] tl,
                                 logic [15:0] sf, logic [15:0] tf,
                                 logic [23:0] per, logic [15:0] rt);
        logic [23:0] vals[7];
        logic [2:0]  idx[7];
        vals = '{24'(mass), 24'(sl), 24'(tl), 24'(sf), 24'(tf), per, 24'(rt)};
        idx = '{lkg_pkg::CFG_BODY_MASS, lkg_pkg::CFG_SHANK_LEN, lkg_pkg::CFG_THIGH_LEN,
                lkg_pkg::CFG_SHANK_FRAC, lkg_pkg::CFG_THIGH_FRAC, lkg_pkg::CFG_PERIOD,
                lkg_pkg::CFG_RATE};
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    // Mostly plausible walking motion with random content, plus raw noise.
    function automatic lkg_pkg::in_item_t rand_sample();
        lkg_pkg::in_item_t s;
        if ($urandom_range(0, 3) == 0) begin
            s = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            s.accel_x = 16'($signed($urandom_range(0, 10240)) - 5120);
            s.accel_y = 16'($signed($urandom_range(0, 10240)) - 5120);
            s.accel_z = 16'($signed($urandom_range(0, 10240)) - 2560);
            s.gyro_x = 16'($signed($urandom_range(0, 16384)) - 8192);
            s.gyro_y = 16'($signed($urandom_range(0, 16384)) - 8192);
            s.gyro_z = 16'($signed($urandom_range(0, 16384)) - 8192);
            s.roll_angle = pick_angle();
            s.pitch_angle = pick_angle();
            s.yaw_angle = pick_angle();
        end
        return s;
    endfunction

    function automatic lkg_pkg::in_item_t fill(logic signed [15:0] a, logic signed [15:0] g,
                                               logic signed [15:0] ang);
        return '{a, a, a, g, g, g, ang, ang, ang};
    endfunction

    task automatic random_run(int count);
        repeat (count) send_sample(rand_sample());
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, quadrant angles, out-of-range angle patterns
        // and wrapping angle steps under the reset settings.
        send_sample(fill(0, 0, 0));
        send_sample(fill(16'sh7FFF, 16'sh7FFF, 16'sd25736));
        send_sample(fill(-16'sh8000, -16'sh8000, -16'sd25736));
        send_sample(fill(16'sh7FFF, -16'sh8000, 16'sh7FFF));
        send_sample(fill(-16'sh8000, 16'sh7FFF, -16'sh8000));
        send_sample(fill(256, 1024, 16'sd12868));
        send_sample(fill(-256, -1024, -16'sd12868));
        send_sample(fill(0, 0, 16'sd6434));
        send_sample(fill(0, 0, 16'sd19302));
        send_sample(fill(16'sh5555, 16'shAAAA, 16'sh5555));
        send_sample(fill(16'shAAAA, 16'sh5555, 16'shAAAA));
        send_sample(fill(1, -1, 1));
        send_sample(fill(-1, 1, -1));
        drain();

        // Extreme settings: everything at its top.
        load_settings(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        send_sample(fill(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_sample(fill(-16'sh8000, -16'sh8000, -16'sh8000));
        send_sample(fill(100, 100, 100));
        random_run(150);
        drain();

        // Zero sample period and zero sample rate; an index past the list is ignored.
        load_settings(16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 24'h000000, 16'h0000);
        cfg_we <= 1;
        cfg_index <= 3'd7;
        cfg_wdata <= 24'hFFFFFF;
        @(posedge aclk);
        cfg_we <= 0;
        send_sample(fill(16'sh7FFF, 16'sh7FFF, 16'sd25736));
        send_sample(fill(-16'sh8000, -16'sh8000, -16'sd25736));
        random_run(100);
        drain();

        // Back to walking-like settings: long receiver hold-off while the
        // sender keeps offering samples.
        load_settings(16'd19200, 8'd40, 8'd50, 16'd37526, 16'd26837, 24'd83886, 16'd200);
        hold_req <= 1;
        @(posedge aclk);
        random_run(20);
        random_run(250);
        drain();

        // Random settings, several phases.
        repeat (5) begin
            load_settings(16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), 24'($urandom_range(1, 16777215)),
                          16'($urandom_range(1, 1000)));
            random_run(140);
            drain();
        end

        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
